// ----- rtl/dcfr_pkg.sv -----
// Shared types, constants and the CRC-8 byte update for the frame relay.
package dcfr_pkg;

  localparam int BYTE_W = 8;
  localparam int POS_W  = 6;

  localparam logic [1:0] MODE_PASS    = 2'd0;
  localparam logic [1:0] MODE_CAPTURE = 2'd1;
  localparam logic [1:0] MODE_SYNC    = 2'd2;

  localparam logic [BYTE_W-1:0] SYNC_START = 8'hFF;
  localparam logic [BYTE_W-1:0] SYNC_END   = 8'hAA;
  localparam logic [BYTE_W-1:0] CAPTURE_ID = 8'h00;
  localparam logic [BYTE_W-1:0] CRC_POLY   = 8'hCF;
  localparam logic [BYTE_W-1:0] CRC_SEED   = 8'd105;

  typedef struct packed {
    logic              framing_error;
    logic [BYTE_W-1:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic              sync_mode;
    logic              crc_good;
    logic              frame_done;
    logic [BYTE_W-1:0] capture_byte;
    logic [POS_W-1:0]  capture_index;
    logic              capture_valid;
    logic [BYTE_W-1:0] forward_byte;
    logic              forward_valid;
  } result_t;

  // CRC-8, most significant bit first, one whole byte per call.
  function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] data);
    logic [BYTE_W-1:0] c;
    c = crc ^ data;
    for (int k = 0; k < BYTE_W; k++) begin
      if (c[BYTE_W-1]) begin
        c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[BYTE_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/dcfr_core.sv -----
// Link mode, frame position and CRC state with the per-byte decision logic.
module dcfr_core #(
  parameter int FRAME_BYTES = 50
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step_en,
  input  dcfr_pkg::item_t  item,
  output dcfr_pkg::result_t result
);

  localparam logic [dcfr_pkg::POS_W:0] FRAME_LEN = FRAME_BYTES[dcfr_pkg::POS_W:0];

  logic [1:0]                    mode_r, mode_nxt;
  logic [dcfr_pkg::POS_W-1:0]    pos_r, pos_nxt;
  logic [dcfr_pkg::BYTE_W-1:0]   crc_r, crc_nxt;

  always_comb begin
    logic                       advance;
    logic [dcfr_pkg::POS_W:0]   pos_inc;
    dcfr_pkg::result_t          res;
    advance  = 1'b0;
    pos_inc  = {1'b0, pos_r} + {{dcfr_pkg::POS_W{1'b0}}, 1'b1};
    res      = '0;
    mode_nxt = mode_r;
    pos_nxt  = pos_r;
    crc_nxt  = crc_r;
    if (!item.framing_error) begin
      if (pos_r == '0) begin
        if (item.rx_byte == dcfr_pkg::CAPTURE_ID) begin
          mode_nxt          = dcfr_pkg::MODE_CAPTURE;
          crc_nxt           = dcfr_pkg::CRC_SEED;
          res.capture_valid = 1'b1;
          advance           = 1'b1;
        end else if (item.rx_byte == dcfr_pkg::SYNC_START) begin
          mode_nxt          = dcfr_pkg::MODE_SYNC;
          pos_nxt           = {{(dcfr_pkg::POS_W-1){1'b0}}, 1'b1};
          res.forward_valid = 1'b1;
          res.forward_byte  = item.rx_byte;
        end else begin
          mode_nxt          = dcfr_pkg::MODE_PASS;
          res.forward_valid = 1'b1;
          res.forward_byte  = item.rx_byte - 8'd1;
          advance           = 1'b1;
        end
      end else if (mode_r == dcfr_pkg::MODE_SYNC) begin
        res.forward_valid = 1'b1;
        res.forward_byte  = item.rx_byte;
        if (item.rx_byte == dcfr_pkg::SYNC_END) begin
          mode_nxt = dcfr_pkg::MODE_PASS;
          pos_nxt  = '0;
        end
      end else if (mode_r == dcfr_pkg::MODE_CAPTURE) begin
        crc_nxt           = dcfr_pkg::crc8_update(crc_r, item.rx_byte);
        res.capture_valid = 1'b1;
        res.capture_index = pos_r;
        res.capture_byte  = item.rx_byte;
        advance           = 1'b1;
      end else begin
        res.forward_valid = 1'b1;
        res.forward_byte  = item.rx_byte;
        advance           = 1'b1;
      end

      if (advance) begin
        if (pos_inc >= FRAME_LEN) begin
          if (mode_nxt == dcfr_pkg::MODE_CAPTURE) begin
            mode_nxt       = dcfr_pkg::MODE_PASS;
            res.frame_done = 1'b1;
            res.crc_good   = (crc_nxt == '0);
          end
          pos_nxt = '0;
        end else begin
          pos_nxt = pos_inc[dcfr_pkg::POS_W-1:0];
        end
      end
    end
    res.sync_mode = (mode_nxt == dcfr_pkg::MODE_SYNC);
    result = res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= dcfr_pkg::MODE_SYNC;
      pos_r  <= '0;
      crc_r  <= dcfr_pkg::CRC_SEED;
    end else if (step_en) begin
      mode_r <= mode_nxt;
      pos_r  <= pos_nxt;
      crc_r  <= crc_nxt;
    end
  end

endmodule

// ----- rtl/daisy_chain_frame_relay_crc8_top.sv -----
// Top level of the daisy-chain frame relay: input register, decision core, result register.
// An accepted input beat is held in the input register, decided by the core, then held in the result register.
// Throughput: one beat per cycle while out_tready stays high; the input register and the result register each
// advance whenever the stage after them is empty or being emptied.
// Reset (rst_n low, synchronous) empties both registers and puts the link in sync
// mode at frame position zero with the CRC seed loaded.
module daisy_chain_frame_relay_crc8_top #(
  parameter int FRAME_BYTES = 50
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tuser,   // [0] framing_error
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [0] forward_valid, [8:1] forward_byte,
                                  // [9] capture_valid, [15:10] capture_index,
                                  // [23:16] capture_byte, [24] crc_good,
                                  // [25] sync_mode, [31:26] zero
  output logic        out_tlast   // frame_done
);

  logic              in_valid_r;
  dcfr_pkg::item_t   in_item_r;
  logic              out_valid_r;
  dcfr_pkg::result_t out_res_r;
  dcfr_pkg::result_t core_res;
  logic              step_en;

  assign step_en   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || step_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (!out_valid_r || out_tready) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_item_r.rx_byte       <= in_tdata;
      in_item_r.framing_error <= in_tuser;
    end
    if (step_en) begin
      out_res_r <= core_res;
    end
  end

  dcfr_core #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_en(step_en),
    .item   (in_item_r),
    .result (core_res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_res_r.frame_done;
  assign out_tdata  = {6'b0,
                       out_res_r.sync_mode,
                       out_res_r.crc_good,
                       out_res_r.capture_byte,
                       out_res_r.capture_index,
                       out_res_r.capture_valid,
                       out_res_r.forward_byte,
                       out_res_r.forward_valid};

endmodule
